// ===== rtl/nfcrf_pkg.sv =====
// Shared types, codes and constants for the NFC response frame parser.
package nfcrf_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned HPOS_W   = 2;

	localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'hFF;

	// Position at which the header check is complete
	localparam logic [HPOS_W-1:0] HPOS_LAST = 2'd3;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [HPOS_W-1:0]   hpos_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEADER = 3'd1,
		PH_LEN    = 3'd2,
		PH_LCS    = 3'd3,
		PH_DATA   = 3'd4,
		PH_DCS    = 3'd5
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 2'd0,
		ST_BAD_PREAMBLE = 2'd1,
		ST_BAD_LENGTH   = 2'd2,
		ST_BAD_CHECKSUM = 2'd3
	} status_t;

	// Expected preamble and start code: 00 00 FF
	function automatic byte_t header_byte(input hpos_t pos);
		byte_t b;
		unique case (pos)
			2'd0:    b = 8'h00;
			2'd1:    b = 8'h00;
			default: b = 8'hFF;
		endcase
		return b;
	endfunction

	// One parsed result
	typedef struct packed {
		logic    valid;
		byte_t   data;
		logic    done;
		status_t status;
	} result_t;

endpackage

// ===== rtl/nfc_response_frame_parser_unit.sv =====
// Top level of the NFC response frame parser: input stage, frame state and result register.
//
// Parses controller response frames one byte per transfer on the slave stream. A transfer
// with s_tuser set starts a new frame. The parser checks the preamble and start code
// 00 00 FF, then checks that length plus length checksum is zero modulo 256 and that the
// length does not exceed the value last written on the cfg channel (255 after reset).
// Every payload byte is passed out at once with m_tuser = ok and m_tlast low; the data
// checksum byte closes the frame with m_tlast high, m_tdata zero and m_tuser giving ok or
// bad checksum. A header or length error closes the frame early with m_tlast high and the
// matching status; bytes after that, the postamble and any idle bytes give no transfer
// until the next frame start. A frame start in the middle of a frame drops the old one
// without a status. Throughput is one byte per clock while the output is not stalled by
// m_tready: the frame state is a handful of registers updated in a single step per byte,
// between an input register and the result register. Write cfg only while no frame is in
// progress; cfg_ready is always high.
module nfc_response_frame_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write: max_payload
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       s_tuser,   // [0] frame_start
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // frame_done
	output logic [1:0] m_tuser    // [1:0] status
);

	// Input register
	logic                 valid_s1;
	nfcrf_pkg::byte_t     byte_s1;
	logic                 start_s1;

	// Frame state
	nfcrf_pkg::phase_t    phase_q;
	nfcrf_pkg::hpos_t     hpos_q;
	nfcrf_pkg::byte_t     len_q;
	nfcrf_pkg::byte_t     left_q;
	nfcrf_pkg::byte_t     sum_q;
	nfcrf_pkg::byte_t     max_payload_q;

	// Result register
	nfcrf_pkg::result_t   res_s2;

	// State as seen by the item in stage 1 (frame start clears it)
	nfcrf_pkg::phase_t    eff_phase;
	nfcrf_pkg::hpos_t     eff_hpos;
	nfcrf_pkg::byte_t     eff_len;
	nfcrf_pkg::byte_t     eff_left;
	nfcrf_pkg::byte_t     eff_sum;

	nfcrf_pkg::phase_t    phase_d;
	nfcrf_pkg::hpos_t     hpos_d;
	nfcrf_pkg::byte_t     len_d;
	nfcrf_pkg::byte_t     left_d;
	nfcrf_pkg::byte_t     sum_d;
	nfcrf_pkg::result_t   res_d;

	logic                 advance;
	logic                 header_bad;
	logic                 length_bad;
	nfcrf_pkg::byte_t     lcs_sum;
	nfcrf_pkg::byte_t     data_sum;
	nfcrf_pkg::byte_t     left_dec;
	nfcrf_pkg::hpos_t     hpos_inc;

	// Stage 1 moves on when the result register can take whatever it yields
	assign advance   = valid_s1 && (!res_s2.valid || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (start_s1) begin
			eff_phase = nfcrf_pkg::PH_HEADER;
			eff_hpos  = '0;
			eff_len   = '0;
			eff_left  = '0;
			eff_sum   = '0;
		end else begin
			eff_phase = phase_q;
			eff_hpos  = hpos_q;
			eff_len   = len_q;
			eff_left  = left_q;
			eff_sum   = sum_q;
		end
	end

	assign header_bad = (eff_hpos == nfcrf_pkg::HPOS_LAST) ||
	                    (byte_s1 != nfcrf_pkg::header_byte(eff_hpos));
	assign lcs_sum    = eff_len + byte_s1;
	assign length_bad = (lcs_sum != '0) || (eff_len > max_payload_q);
	assign data_sum   = eff_sum + byte_s1;
	assign left_dec   = eff_left - 8'd1;
	assign hpos_inc   = eff_hpos + 2'd1;

	// Next state
	always_comb begin
		phase_d = eff_phase;
		hpos_d  = eff_hpos;
		len_d   = eff_len;
		left_d  = eff_left;
		sum_d   = eff_sum;
		unique case (eff_phase)
			nfcrf_pkg::PH_HEADER: begin
				if (header_bad) begin
					phase_d = nfcrf_pkg::PH_IDLE;
				end else begin
					hpos_d = hpos_inc;
					if (hpos_inc == nfcrf_pkg::HPOS_LAST) begin
						phase_d = nfcrf_pkg::PH_LEN;
					end
				end
			end
			nfcrf_pkg::PH_LEN: begin
				len_d   = byte_s1;
				phase_d = nfcrf_pkg::PH_LCS;
			end
			nfcrf_pkg::PH_LCS: begin
				if (length_bad) begin
					phase_d = nfcrf_pkg::PH_IDLE;
				end else begin
					left_d  = eff_len;
					sum_d   = '0;
					phase_d = (eff_len == '0) ? nfcrf_pkg::PH_DCS : nfcrf_pkg::PH_DATA;
				end
			end
			nfcrf_pkg::PH_DATA: begin
				sum_d  = data_sum;
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = nfcrf_pkg::PH_DCS;
				end
			end
			nfcrf_pkg::PH_DCS: begin
				phase_d = nfcrf_pkg::PH_IDLE;
			end
			default: begin
				phase_d = nfcrf_pkg::PH_IDLE;
			end
		endcase
	end

	// Result for the item in stage 1
	always_comb begin
		res_d        = '0;
		res_d.status = nfcrf_pkg::ST_OK;
		unique case (eff_phase)
			nfcrf_pkg::PH_HEADER: begin
				if (header_bad) begin
					res_d.valid  = 1'b1;
					res_d.done   = 1'b1;
					res_d.status = nfcrf_pkg::ST_BAD_PREAMBLE;
				end
			end
			nfcrf_pkg::PH_LCS: begin
				if (length_bad) begin
					res_d.valid  = 1'b1;
					res_d.done   = 1'b1;
					res_d.status = nfcrf_pkg::ST_BAD_LENGTH;
				end
			end
			nfcrf_pkg::PH_DATA: begin
				res_d.valid = 1'b1;
				res_d.data  = byte_s1;
			end
			nfcrf_pkg::PH_DCS: begin
				res_d.valid  = 1'b1;
				res_d.done   = 1'b1;
				res_d.status = (data_sum == '0) ? nfcrf_pkg::ST_OK
				                                : nfcrf_pkg::ST_BAD_CHECKSUM;
			end
			default: begin
				res_d.valid = 1'b0;
			end
		endcase
	end

	// Input register: hold while stage 1 is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// Frame state: advance once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nfcrf_pkg::PH_IDLE;
			hpos_q  <= '0;
			len_q   <= '0;
			left_q  <= '0;
			sum_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			hpos_q  <= hpos_d;
			len_q   <= len_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= nfcrf_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	// Result register: load a new result, or drop the old one once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (advance) begin
			res_s2 <= res_d;
		end else if (m_tready) begin
			res_s2.valid <= 1'b0;
		end
	end

	assign m_tvalid = res_s2.valid;
	assign m_tdata  = res_s2.data;
	assign m_tlast  = res_s2.done;
	assign m_tuser  = res_s2.status;

	// A data byte always carries ok status
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == nfcrf_pkg::ST_OK)
		else $error("data transfer with non-ok status");

	// A status transfer carries a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == '0)
		else $error("status transfer with nonzero byte");

	// In the payload phase at least one byte is still due
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == nfcrf_pkg::PH_DATA |-> left_q != '0)
		else $error("payload phase with no bytes left");

	// The header check never runs past the start code
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == nfcrf_pkg::PH_HEADER |-> hpos_q != nfcrf_pkg::HPOS_LAST)
		else $error("header position past start code");

endmodule

// ===== test/nfc_response_frame_parser_unit_test.sv =====
// Self-checking stream test of the NFC response frame parser with random frames and stalls.
module nfc_response_frame_parser_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 3;
	localparam int TAIL_CYCLES  = 6;
	localparam int RANDOM_ITEMS = 960;
	localparam int RANDOM_PASSES = 6;
	localparam int REPORT_LIMIT = 10;
	localparam int HEADER_LEN   = 3;
	localparam int LCS_POS      = 4;

	localparam nfcrf_pkg::byte_t PREAMBLE_BYTE = 8'h00;
	localparam nfcrf_pkg::byte_t START_CODE    = 8'hFF;
	localparam nfcrf_pkg::byte_t POSTAMBLE     = 8'h00;

	// One result as the parser should deliver it
	typedef struct packed {
		nfcrf_pkg::byte_t   data;
		logic               done;
		nfcrf_pkg::status_t status;
	} frame_result_t;

	// Ways a generated frame can be damaged
	typedef enum int {
		FLAW_NONE,
		FLAW_PREAMBLE,
		FLAW_LENGTH_SUM,
		FLAW_CHECKSUM,
		FLAW_CUT
	} flaw_t;

	// Output-side back-pressure styles
	typedef enum int {
		RX_ALWAYS,
		RX_LIGHT,
		RX_HEAVY,
		RX_PATTERN
	} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] rx_byte
	logic       s_tuser;   // [0] frame_start
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;   // [7:0] out_byte
	logic       m_tlast;   // frame_done
	logic [1:0] m_tuser;   // [1:0] status

	// Parser shadow state and the results it still owes
	nfcrf_pkg::phase_t pm_phase;
	nfcrf_pkg::hpos_t  pm_hpos;
	nfcrf_pkg::byte_t  pm_len;
	nfcrf_pkg::byte_t  pm_left;
	nfcrf_pkg::byte_t  pm_sum;
	nfcrf_pkg::byte_t  pm_max;
	frame_result_t frame_results_due[$];

	int items_parsed;
	int results_checked;
	int frames_sent;
	int cfg_writes;
	int mismatches;

	int       burst_left;
	int       gap_max;
	rx_mode_t rx_mode;
	int       rx_tick = 0;

	always #CLK_HALF clk = ~clk;

	nfc_response_frame_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// End the frame with a status result and go idle
	task automatic close_frame(input nfcrf_pkg::status_t st);
		pm_phase = nfcrf_pkg::PH_IDLE;
		frame_results_due.push_back(frame_result_t'{8'h00, 1'b1, st});
	endtask

	// Advance the shadow parser by one accepted byte
	task automatic parse_frame_byte(input nfcrf_pkg::byte_t b, input logic start);
		nfcrf_pkg::byte_t hdr;
		if (start) begin
			pm_phase = nfcrf_pkg::PH_HEADER;
			pm_hpos  = '0;
			pm_len   = '0;
			pm_left  = '0;
			pm_sum   = '0;
		end
		if (pm_phase != nfcrf_pkg::PH_IDLE)
			items_parsed++;
		case (pm_phase)
			nfcrf_pkg::PH_HEADER: begin
				hdr = (pm_hpos == nfcrf_pkg::hpos_t'(HEADER_LEN - 1)) ?
					START_CODE : PREAMBLE_BYTE;
				if (pm_hpos >= nfcrf_pkg::HPOS_LAST || b != hdr) begin
					close_frame(nfcrf_pkg::ST_BAD_PREAMBLE);
				end else begin
					pm_hpos = pm_hpos + 1'b1;
					if (pm_hpos == nfcrf_pkg::HPOS_LAST)
						pm_phase = nfcrf_pkg::PH_LEN;
				end
			end
			nfcrf_pkg::PH_LEN: begin
				pm_len   = b;
				pm_phase = nfcrf_pkg::PH_LCS;
			end
			nfcrf_pkg::PH_LCS: begin
				if (nfcrf_pkg::byte_t'(pm_len + b) != 8'h00 || pm_len > pm_max) begin
					close_frame(nfcrf_pkg::ST_BAD_LENGTH);
				end else begin
					pm_left  = pm_len;
					pm_sum   = '0;
					pm_phase = (pm_left == 8'h00) ? nfcrf_pkg::PH_DCS : nfcrf_pkg::PH_DATA;
				end
			end
			nfcrf_pkg::PH_DATA: begin
				pm_sum  = pm_sum + b;
				pm_left = pm_left - 1'b1;
				if (pm_left == 8'h00)
					pm_phase = nfcrf_pkg::PH_DCS;
				frame_results_due.push_back(frame_result_t'{b, 1'b0, nfcrf_pkg::ST_OK});
			end
			nfcrf_pkg::PH_DCS: begin
				if (nfcrf_pkg::byte_t'(pm_sum + b) != 8'h00)
					close_frame(nfcrf_pkg::ST_BAD_CHECKSUM);
				else
					close_frame(nfcrf_pkg::ST_OK);
			end
			default: pm_phase = nfcrf_pkg::PH_IDLE;
		endcase
	endtask

	// Drive one byte, with a random gap at the start of each burst, and wait for the transfer
	task automatic send_byte(input nfcrf_pkg::byte_t b, input logic start);
		int gap;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				@(negedge clk) s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		parse_frame_byte(b, start);
		burst_left--;
	endtask

	// Send a byte run; the first byte carries the frame start flag
	task automatic send_bytes(input nfcrf_pkg::byte_t seq[$]);
		foreach (seq[i])
			send_byte(seq[i], i == 0);
	endtask

	// Build a frame of the given payload length, damage it as asked, and send it
	task automatic send_frame(input int len, input flaw_t flaw);
		nfcrf_pkg::byte_t seq[$];
		nfcrf_pkg::byte_t sum;
		nfcrf_pkg::byte_t d;
		int    pos;
		seq = {PREAMBLE_BYTE, PREAMBLE_BYTE, START_CODE, nfcrf_pkg::byte_t'(len),
			nfcrf_pkg::byte_t'(256 - len)};
		sum = '0;
		repeat (len) begin
			d = nfcrf_pkg::byte_t'($urandom);
			seq.push_back(d);
			sum = sum + d;
		end
		seq.push_back(nfcrf_pkg::byte_t'(8'h00 - sum));
		seq.push_back(POSTAMBLE);
		case (flaw)
			FLAW_PREAMBLE: begin
				pos = $urandom_range(0, HEADER_LEN - 1);
				seq[pos] = seq[pos] ^ nfcrf_pkg::byte_t'($urandom_range(1, 255));
			end
			FLAW_LENGTH_SUM:
				seq[LCS_POS] = seq[LCS_POS] ^ nfcrf_pkg::byte_t'($urandom_range(1, 255));
			FLAW_CHECKSUM: begin
				pos = seq.size() - 2;
				seq[pos] = seq[pos] ^ nfcrf_pkg::byte_t'($urandom_range(1, 255));
			end
			FLAW_CUT: begin
				// drop the tail so the next frame start abandons this one
				pos = $urandom_range(1, seq.size() - 2);
				while (seq.size() > pos) seq.pop_back();
			end
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) seq.push_back(nfcrf_pkg::byte_t'($urandom));
		send_bytes(seq);
		frames_sent++;
	endtask

	// Close any open frame, hold the input idle and let every owed result drain
	task automatic settle_parser();
		if (pm_phase != nfcrf_pkg::PH_IDLE)
			send_byte(8'h01, 1'b1);
		@(negedge clk) s_tvalid <= 1'b0;
		while (frame_results_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_max_payload(input nfcrf_pkg::byte_t value);
		settle_parser();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		pm_max = value;
		cfg_writes++;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Header, length and checksum corner cases at the reset limit of 255
	task automatic test_frame_cases();
		nfcrf_pkg::byte_t seq[$];
		rx_mode = RX_LIGHT;
		gap_max = 2;
		// zero length, checksum 00, then postamble and a stray idle byte
		seq = {PREAMBLE_BYTE, PREAMBLE_BYTE, START_CODE, 8'h00, 8'h00, 8'h00, POSTAMBLE};
		send_bytes(seq);
		send_byte(8'hFF, 1'b0);
		// preamble mismatch on each header position
		seq = {8'h01};
		send_bytes(seq);
		seq = {PREAMBLE_BYTE, 8'h80};
		send_bytes(seq);
		seq = {PREAMBLE_BYTE, PREAMBLE_BYTE, 8'h7F};
		send_bytes(seq);
		// payload FF 80 with a wrong data checksum
		seq = {PREAMBLE_BYTE, PREAMBLE_BYTE, START_CODE, 8'h02, 8'hFE, 8'hFF, 8'h80, 8'h80};
		send_bytes(seq);
		// open a frame, then restart it with one whose length checksum is off by one
		seq = {PREAMBLE_BYTE, PREAMBLE_BYTE, START_CODE};
		send_bytes(seq);
		seq = {PREAMBLE_BYTE, PREAMBLE_BYTE, START_CODE, 8'h03, 8'hFC};
		send_bytes(seq);
	endtask

	// Payload limit at its extremes and at a random value, one past it where it is below 255
	task automatic test_payload_limit();
		int cap;
		rx_mode = RX_PATTERN;
		gap_max = 4;
		write_max_payload(8'h00);
		send_frame(0, FLAW_NONE);
		send_frame(1, FLAW_NONE);
		write_max_payload(8'hFF);
		send_frame(255, FLAW_NONE);
		cap = $urandom_range(1, 254);
		write_max_payload(nfcrf_pkg::byte_t'(cap));
		send_frame(cap, FLAW_NONE);
		send_frame(cap + 1, FLAW_NONE);
	endtask

	// Mostly well-formed frames with random payloads, some damaged, under varied pressure
	task automatic test_random_traffic();
		int    base;
		int    pick;
		int    len;
		nfcrf_pkg::byte_t cap;
		flaw_t flaw;
		for (int pass = 0; pass < RANDOM_PASSES; pass++) begin
			case (pass)
				0: cap = 8'hFF;
				1: cap = nfcrf_pkg::byte_t'($urandom_range(8, 40));
				2: cap = nfcrf_pkg::byte_t'($urandom);
				3: cap = 8'd12;
				4: cap = nfcrf_pkg::byte_t'($urandom_range(1, 6));
				default: cap = 8'hFF;
			endcase
			write_max_payload(cap);
			// first pass runs with no idling on either side
			rx_mode = rx_mode_t'(pass % 4);
			gap_max = (pass == 0) ? 0 : $urandom_range(1, 12);
			base = items_parsed;
			while (items_parsed - base < RANDOM_ITEMS / RANDOM_PASSES) begin
				pick = $urandom_range(0, 99);
				if (pick < 85)
					len = $urandom_range(0, 12);
				else if (pick < 95)
					len = $urandom_range(0, 40);
				else
					len = $urandom_range(0, 255);
				pick = $urandom_range(0, 99);
				if (pick < 70)
					flaw = FLAW_NONE;
				else if (pick < 78)
					flaw = FLAW_PREAMBLE;
				else if (pick < 85)
					flaw = FLAW_LENGTH_SUM;
				else if (pick < 93)
					flaw = FLAW_CHECKSUM;
				else
					flaw = FLAW_CUT;
				if ($urandom_range(0, 7) == 0)
					repeat ($urandom_range(1, 3))
						send_byte(nfcrf_pkg::byte_t'($urandom), 1'b0);
				send_frame(len, flaw);
			end
		end
	endtask

	// Output back-pressure, updated on the falling edge
	always @(negedge clk) begin
		rx_tick++;
		case (rx_mode)
			RX_ALWAYS:  m_tready <= 1'b1;
			RX_LIGHT:   m_tready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY:   m_tready <= ($urandom_range(0, 2) == 0);
			RX_PATTERN: m_tready <= ((rx_tick % 9) < 5);
			default:    m_tready <= 1'b1;
		endcase
	end

	// Compare every output transfer with the oldest owed result
	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (frame_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: data %h last %b status %0d",
						m_tdata, m_tlast, m_tuser);
			end else begin
				want = frame_results_due.pop_front();
				if (m_tdata !== want.data || m_tlast !== want.done ||
					m_tuser !== want.status) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch: data %h/%h last %b/%b status %0d/%0d (want/got)",
							want.data, m_tdata, want.done, m_tlast, want.status, m_tuser);
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		rx_mode   = RX_ALWAYS;
		gap_max   = 0;
		burst_left = 0;
		items_parsed    = 0;
		results_checked = 0;
		frames_sent     = 0;
		cfg_writes      = 0;
		mismatches      = 0;
		pm_phase = nfcrf_pkg::PH_IDLE;
		pm_hpos  = '0;
		pm_len   = '0;
		pm_left  = '0;
		pm_sum   = '0;
		pm_max   = nfcrf_pkg::MAX_PAYLOAD_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_frame_cases();
		test_payload_limit();
		test_random_traffic();
		settle_parser();

		$display("covered %0d frames, %0d parsed bytes, %0d results, %0d limit writes",
			frames_sent, items_parsed, results_checked, cfg_writes);
		$display("mismatching or stray results: %0d", mismatches);
		if (mismatches == 0 && frame_results_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
